@@ rtl/core/tbwm_pkg.sv @@
// shared types and constants of the trie banned word matcher
`timescale 1ns / 1ps
package tbwm_pkg;

  localparam int NODE_CAPACITY = 1024;
  localparam int MAX_WORD_LEN  = 16;
  localparam int CHAR_BITS     = 16;

  localparam int NODE_BITS = $clog2(NODE_CAPACITY);
  localparam int USED_BITS = $clog2(NODE_CAPACITY + 1);
  localparam int WK_BITS   = (MAX_WORD_LEN > 1) ? $clog2(MAX_WORD_LEN) : 1;
  localparam int WCNT_BITS = $clog2(MAX_WORD_LEN + 1);
  localparam int KEY_BITS  = NODE_BITS + CHAR_BITS;
  // pointer with a valid flag on top
  localparam int PTR_BITS  = NODE_BITS + 1;
  localparam int EDGE_BITS = KEY_BITS + PTR_BITS;

  localparam logic [1:0] LEAF_NONE  = 2'd0;
  localparam logic [1:0] LEAF_BLACK = 2'd1;

  localparam logic [1:0] ERR_NONE = 2'd0;
  localparam logic [1:0] ERR_FULL = 2'd1;
  localparam logic [1:0] ERR_LONG = 2'd2;

  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_TEXT   = 1'b1;

  typedef struct packed {
    logic        req_type;
    logic [15:0] ch;
    logic        is_last;
    logic [1:0]  leaf_type;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } front_out_t;

  // xor fold of parent node and character into a bucket index
  function automatic logic [NODE_BITS-1:0] bucket(input logic [NODE_BITS-1:0] parent,
                                                  input logic [CHAR_BITS-1:0] c);
    logic [NODE_BITS-1:0] h;
    h = parent;
    for (int i = 0; i < CHAR_BITS; i++) begin
      h[i % NODE_BITS] = h[i % NODE_BITS] ^ c[i];
    end
    return h;
  endfunction

endpackage

@@ rtl/core/trie_banned_word_matcher.sv @@
// top level of the trie banned word matcher
`timescale 1ns / 1ps
// insert character: walks the edge chain of one hash bucket
// text character: scans every walker slot, does one chain lookup per live walker,
// then one chain lookup from the root, and reads the leaf of every hit
// one item at a time in the engine; a two entry queue and an output register decouple the ports
// result of a last character is registered at its finish step
// rst is synchronous; after reset a pass over all 1024 bucket heads clears them before items run
module trie_banned_word_matcher (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // ch [15:0], leaf_type [17:16], zero fill [23:18]
  input  logic        s_tlast,   // is_last
  input  logic        s_tuser,   // req_type
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // text_ok [0], error_code [2:1], zero fill [7:3]
  output logic        m_tuser    // result_kind
);

  tbwm_pkg::item_t      in_item;
  tbwm_pkg::front_out_t head;
  logic                 pop;
  logic                 res_ok;
  logic [1:0]           res_err;

  // unpack the slave transfer into one item
  assign in_item.req_type  = s_tuser;
  assign in_item.ch        = s_tdata[15:0];
  assign in_item.is_last   = s_tlast;
  assign in_item.leaf_type = s_tdata[17:16];

  tbwm_front u_front (
    .clk(clk), .rst(rst),
    .in_valid(s_tvalid), .in_ready(s_tready), .in_item(in_item),
    .head(head), .pop(pop)
  );

  // engine owns the tries stores, the walkers and the output register
  tbwm_engine u_engine (
    .clk(clk), .rst(rst),
    .head(head), .pop(pop),
    .res_valid(m_tvalid), .res_ready(m_tready),
    .res_kind(m_tuser), .res_ok(res_ok), .res_err(res_err)
  );

  assign m_tdata = {5'b0, res_err, res_ok};

endmodule

@@ rtl/core/tbwm_ram.sv @@
// generic simple dual port ram with registered read
`timescale 1ns / 1ps
module tbwm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/core/tbwm_front.sv @@
// input side: accepts items into a two entry queue for the engine
`timescale 1ns / 1ps
module tbwm_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  tbwm_pkg::item_t     in_item,
  output tbwm_pkg::front_out_t head,
  input  logic                pop
);

  tbwm_pkg::item_t slot [2];
  logic       rd_ptr;
  logic       wr_ptr;
  logic [1:0] count;
  logic       push;
  logic       take;

  assign in_ready = (count != 2'd2);
  assign push     = in_valid && in_ready;
  assign take     = pop && (count != 2'd0);

  assign head.valid = (count != 2'd0);
  assign head.item  = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= in_item;
    end
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (take) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, take};
    end
  end

endmodule

@@ rtl/core/tbwm_engine.sv @@
// back side: trie insert and walker sequencer with edge hash chains
`timescale 1ns / 1ps
module tbwm_engine (
  input  logic                 clk,
  input  logic                 rst,
  input  tbwm_pkg::front_out_t head,
  output logic                 pop,
  output logic                 res_valid,
  input  logic                 res_ready,
  output logic                 res_kind,
  output logic                 res_ok,
  output logic [1:0]           res_err
);

  localparam int NB = tbwm_pkg::NODE_BITS;
  localparam int CB = tbwm_pkg::CHAR_BITS;
  localparam int WK_IDX = tbwm_pkg::WK_BITS;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_WSCAN, S_HEAD, S_HWAIT, S_EWAIT, S_RES, S_LEAF, S_FINISH
  } state_t;

  typedef enum logic [1:0] {M_INS, M_WALK, M_ROOT} mode_t;

  state_t state;
  mode_t  mode;

  tbwm_pkg::item_t cur;
  logic [NB-1:0]   clr_cnt;
  logic [tbwm_pkg::USED_BITS-1:0] nodes_used;
  logic [NB-1:0]   cursor;
  logic [tbwm_pkg::WCNT_BITS-1:0] ins_len;
  logic [1:0]      ins_err;
  logic [NB-1:0]   lk_parent;
  logic [tbwm_pkg::PTR_BITS-1:0] head_q;
  logic [NB-1:0]   e_cur;
  logic [NB-1:0]   child_q;
  logic            hit_q;
  logic [tbwm_pkg::WCNT_BITS-1:0] k;
  logic [NB-1:0]   w_node [tbwm_pkg::MAX_WORD_LEN];
  logic [1:0]      w_best [tbwm_pkg::MAX_WORD_LEN];
  logic [tbwm_pkg::MAX_WORD_LEN-1:0] w_alive;
  logic            failed;

  logic [CB-1:0]   c;
  logic [NB-1:0]   hash;
  logic            creating;
  logic [NB-1:0]   e_new;
  logic [WK_IDX-1:0] kk;

  logic                          head_we;
  logic [NB-1:0]                 head_waddr;
  logic [tbwm_pkg::PTR_BITS-1:0] head_wdata;
  logic [tbwm_pkg::PTR_BITS-1:0] head_rd;
  logic                          edge_we;
  logic [NB-1:0]                 edge_raddr;
  logic [tbwm_pkg::EDGE_BITS-1:0] edge_rd;
  logic                          leaf_we;
  logic [NB-1:0]                 leaf_waddr;
  logic [1:0]                    leaf_wdata;
  logic [1:0]                    leaf_rd;

  logic [tbwm_pkg::KEY_BITS-1:0] edge_key;
  logic [tbwm_pkg::PTR_BITS-1:0] edge_next;
  logic                          key_match;
  logic [WK_IDX-1:0]             free_slot;
  logic                          free_any;
  logic                          end_fail;
  logic                          emit_ok;
  logic                          emit;

  assign c    = cur.ch[CB-1:0];
  assign hash = tbwm_pkg::bucket(lk_parent, c);
  assign kk   = k[WK_IDX-1:0];
  assign e_new = NB'(nodes_used - 1'b1);
  assign creating = (state == S_RES) && (mode == M_INS) && !hit_q &&
                    (nodes_used < tbwm_pkg::USED_BITS'(tbwm_pkg::NODE_CAPACITY));

  assign edge_key  = edge_rd[tbwm_pkg::EDGE_BITS-1 -: tbwm_pkg::KEY_BITS];
  assign edge_next = edge_rd[tbwm_pkg::PTR_BITS-1:0];
  assign key_match = (edge_key == {lk_parent, c});

  assign emit_ok = !res_valid || res_ready;
  assign emit    = (state == S_FINISH) && cur.is_last && emit_ok;
  assign pop     = (state == S_IDLE) && head.valid;

  // bucket heads: cleared after reset, prepend on edge creation
  assign head_we    = (state == S_CLEAR) || creating;
  assign head_waddr = (state == S_CLEAR) ? clr_cnt : hash;
  assign head_wdata = (state == S_CLEAR) ? '0 : {1'b1, e_new};

  assign edge_we    = creating;
  assign edge_raddr = (state == S_HWAIT) ? head_rd[NB-1:0] : edge_next[NB-1:0];

  assign leaf_we    = creating ||
                      ((state == S_FINISH) && cur.is_last && emit_ok &&
                       (cur.req_type == tbwm_pkg::REQ_INSERT) &&
                       (ins_err == tbwm_pkg::ERR_NONE));
  assign leaf_waddr = creating ? NB'(nodes_used) : cursor;
  assign leaf_wdata = creating ? tbwm_pkg::LEAF_NONE : cur.leaf_type;

  always_comb begin
    free_slot = '0;
    free_any  = 1'b0;
    for (int i = tbwm_pkg::MAX_WORD_LEN - 1; i >= 0; i--) begin
      if (!w_alive[i]) begin
        free_slot = WK_IDX'(i);
        free_any  = 1'b1;
      end
    end
  end

  always_comb begin
    end_fail = failed;
    for (int i = 0; i < tbwm_pkg::MAX_WORD_LEN; i++) begin
      if (w_alive[i] && (w_best[i] == tbwm_pkg::LEAF_BLACK)) end_fail = 1'b1;
    end
  end

  tbwm_ram #(.WIDTH(tbwm_pkg::PTR_BITS), .DEPTH(tbwm_pkg::NODE_CAPACITY)) u_head (
    .clk(clk), .we(head_we), .waddr(head_waddr), .wdata(head_wdata),
    .raddr(hash), .rdata(head_rd)
  );

  tbwm_ram #(.WIDTH(tbwm_pkg::EDGE_BITS), .DEPTH(tbwm_pkg::NODE_CAPACITY)) u_edge (
    .clk(clk), .we(edge_we), .waddr(e_new), .wdata({lk_parent, c, head_q}),
    .raddr(edge_raddr), .rdata(edge_rd)
  );

  tbwm_ram #(.WIDTH(2), .DEPTH(tbwm_pkg::NODE_CAPACITY)) u_leaf (
    .clk(clk), .we(leaf_we), .waddr(leaf_waddr), .wdata(leaf_wdata),
    .raddr(child_q), .rdata(leaf_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      mode       <= M_INS;
      clr_cnt    <= '0;
      nodes_used <= tbwm_pkg::USED_BITS'(1);
      cursor     <= '0;
      ins_len    <= '0;
      ins_err    <= tbwm_pkg::ERR_NONE;
      w_alive    <= '0;
      failed     <= 1'b0;
      res_valid  <= 1'b0;
      k          <= '0;
    end else begin
      if (emit) begin
        res_valid <= 1'b1;
      end else if (res_valid && res_ready) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == NB'(tbwm_pkg::NODE_CAPACITY - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (head.valid) begin
            cur <= head.item;
            if (head.item.req_type == tbwm_pkg::REQ_INSERT) begin
              mode <= M_INS;
              if (ins_err != tbwm_pkg::ERR_NONE) begin
                state <= S_FINISH;
              end else if (ins_len >= tbwm_pkg::WCNT_BITS'(tbwm_pkg::MAX_WORD_LEN)) begin
                ins_err <= tbwm_pkg::ERR_LONG;
                state   <= S_FINISH;
              end else begin
                ins_len   <= ins_len + 1'b1;
                lk_parent <= cursor;
                state     <= S_HEAD;
              end
            end else begin
              k     <= '0;
              state <= S_WSCAN;
            end
          end
        end
        S_WSCAN: begin
          if (k == tbwm_pkg::WCNT_BITS'(tbwm_pkg::MAX_WORD_LEN)) begin
            mode      <= M_ROOT;
            lk_parent <= '0;
            state     <= S_HEAD;
          end else if (w_alive[kk]) begin
            mode      <= M_WALK;
            lk_parent <= w_node[kk];
            state     <= S_HEAD;
          end else begin
            k <= k + 1'b1;
          end
        end
        S_HEAD: state <= S_HWAIT;
        S_HWAIT: begin
          head_q <= head_rd;
          e_cur  <= head_rd[NB-1:0];
          if (head_rd[NB]) begin
            state <= S_EWAIT;
          end else begin
            hit_q <= 1'b0;
            state <= S_RES;
          end
        end
        S_EWAIT: begin
          if (key_match) begin
            hit_q   <= 1'b1;
            child_q <= e_cur + 1'b1;
            state   <= S_RES;
          end else if (!edge_next[NB]) begin
            hit_q <= 1'b0;
            state <= S_RES;
          end else begin
            e_cur <= edge_next[NB-1:0];
          end
        end
        S_RES: begin
          case (mode)
            M_INS: begin
              if (hit_q) begin
                cursor <= child_q;
              end else if (creating) begin
                cursor     <= NB'(nodes_used);
                nodes_used <= nodes_used + 1'b1;
              end else begin
                ins_err <= tbwm_pkg::ERR_FULL;
              end
              state <= S_FINISH;
            end
            M_WALK: begin
              if (hit_q) begin
                state <= S_LEAF;
              end else begin
                if (w_best[kk] == tbwm_pkg::LEAF_BLACK) failed <= 1'b1;
                w_alive[kk] <= 1'b0;
                k     <= k + 1'b1;
                state <= S_WSCAN;
              end
            end
            default: state <= hit_q ? S_LEAF : S_FINISH;
          endcase
        end
        S_LEAF: begin
          if (mode == M_WALK) begin
            w_node[kk] <= child_q;
            if (leaf_rd != tbwm_pkg::LEAF_NONE) w_best[kk] <= leaf_rd;
            k     <= k + 1'b1;
            state <= S_WSCAN;
          end else begin
            if (free_any) begin
              w_alive[free_slot] <= 1'b1;
              w_node[free_slot]  <= child_q;
              w_best[free_slot]  <= leaf_rd;
            end
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (!cur.is_last) begin
            state <= S_IDLE;
          end else if (emit_ok) begin
            if (cur.req_type == tbwm_pkg::REQ_INSERT) begin
              res_kind <= tbwm_pkg::REQ_INSERT;
              res_ok   <= 1'b0;
              res_err  <= ins_err;
              cursor   <= '0;
              ins_len  <= '0;
              ins_err  <= tbwm_pkg::ERR_NONE;
            end else begin
              res_kind <= tbwm_pkg::REQ_TEXT;
              res_ok   <= !end_fail;
              res_err  <= tbwm_pkg::ERR_NONE;
              w_alive  <= '0;
              failed   <= 1'b0;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
